// ===== rtl/core/rmth_pkg.sv =====
package rmth_pkg;

  // Width of the sample count reported with every result.
  localparam int unsigned COUNT_BITS = 11;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_BALANCE,
    ST_REPORT
  } state_e;

  // Operation applied to every cell of a chain together.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } chain_op_e;

endpackage

// ===== rtl/core/rmth_cell.sv =====
module rmth_cell import rmth_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter bit          IS_MAX      = 1'b1
) (
  input  logic                          clk_i,
  input  chain_op_e                     op_i,
  input  logic signed [SAMPLE_BITS-1:0] new_val_i,
  input  logic                          occ_i,
  input  logic                          prev_keep_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_val_i,
  input  logic signed [SAMPLE_BITS-1:0] next_val_i,
  output logic                          keep_o,
  output logic signed [SAMPLE_BITS-1:0] val_o
);

  logic signed [SAMPLE_BITS-1:0] val_q;
  logic signed [SAMPLE_BITS-1:0] val_d;

  // The held value stays in place when it belongs above the new value.
  always_comb begin
    if (IS_MAX) begin
      keep_o = occ_i && (val_q >= new_val_i);
    end else begin
      keep_o = occ_i && (val_q <= new_val_i);
    end
  end

  // Insert shifts the tail one place away from the top; pop shifts it toward the top.
  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_INSERT: begin
        if (!keep_o) begin
          val_d = prev_keep_i ? new_val_i : prev_val_i;
        end
      end
      OP_POP: begin
        val_d = next_val_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/core/rmth_chain.sv =====
module rmth_chain import rmth_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned DEPTH       = 513,
  parameter int unsigned SIZE_BITS   = 10,
  parameter bit          IS_MAX      = 1'b1
) (
  input  logic                          clk_i,
  input  chain_op_e                     op_i,
  input  logic signed [SAMPLE_BITS-1:0] val_i,
  input  logic [SIZE_BITS-1:0]          size_i,
  output logic signed [SAMPLE_BITS-1:0] top_o
);

  logic                          keep [DEPTH];
  logic signed [SAMPLE_BITS-1:0] vals [DEPTH];

  // A sorted row of cells; the top of the heap always sits in the first cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          occ;
    logic                          prev_keep;
    logic signed [SAMPLE_BITS-1:0] prev_val;
    logic signed [SAMPLE_BITS-1:0] next_val;

    assign occ = (SIZE_BITS'(i) < size_i);

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_val  = val_i;
    end else begin : g_rest
      assign prev_keep = keep[i-1];
      assign prev_val  = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    rmth_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IS_MAX      (IS_MAX)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op_i),
      .new_val_i   (val_i),
      .occ_i       (occ),
      .prev_keep_i (prev_keep),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .keep_o      (keep[i]),
      .val_o       (vals[i])
    );
  end

  assign top_o = vals[0];

endmodule

// ===== rtl/core/running_median_two_heaps_unit.sv =====
// Running median of signed samples. Each accepted sample adds to the set and
// returns one result: twice the median of all samples held (an exact integer),
// the number held, and a flag that is set when the set already held CAPACITY
// samples and the new one was discarded. Samples are kept in two sorted rows
// of register cells, the lower half largest-first and the upper half
// smallest-first, so both middle values sit at fixed places. A kept sample
// passes through the sequencer in order: it is accepted, shifted into its
// row, then a value moves across when the halves differ by more than one,
// and then the result is formed. A discarded sample is not shifted in and
// skips the move. The single sequencer works on one sample at a time. A
// result waits in an output register, and the next sample is accepted
// while it waits; forming the following result waits for as long as the
// previous one is still stalled. No clearing pass is needed after reset.
module running_median_two_heaps_unit import rmth_pkg::*; #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_BITS:0] median_x2_o,
  output logic [COUNT_BITS-1:0]       count_o,
  output logic                        dropped_o
);

  localparam int unsigned HEAP_DEPTH = CAPACITY / 2 + 1;
  localparam int unsigned SW         = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TW         = SW + 1;
  localparam int unsigned MW         = SAMPLE_BITS + 1;

  state_e                        state_q, state_d;
  logic [SW-1:0]                 lsize_q, lsize_d;
  logic [SW-1:0]                 usize_q, usize_d;
  logic                          dropped_q, dropped_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_valid_q, out_valid_d;
  logic signed [MW-1:0]          median_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic                          dropped_out_q;
  logic                          out_load;

  chain_op_e                     lop, uop;
  logic signed [SAMPLE_BITS-1:0] lval, uval;
  logic signed [SAMPLE_BITS-1:0] ltop, utop;

  logic [TW-1:0]                 total;
  logic [TW-1:0]                 lsize_w, usize_w;
  logic signed [MW-1:0]          lt_ext, ut_ext, samp_ext;
  logic signed [MW-1:0]          m2, m2_adj, mt;

  // Lower half: largest value on top.
  rmth_chain #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (HEAP_DEPTH),
    .SIZE_BITS   (SW),
    .IS_MAX      (1'b1)
  ) u_lower (
    .clk_i  (clk_i),
    .op_i   (lop),
    .val_i  (lval),
    .size_i (lsize_q),
    .top_o  (ltop)
  );

  // Upper half: smallest value on top.
  rmth_chain #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (HEAP_DEPTH),
    .SIZE_BITS   (SW),
    .IS_MAX      (1'b0)
  ) u_upper (
    .clk_i  (clk_i),
    .op_i   (uop),
    .val_i  (uval),
    .size_i (usize_q),
    .top_o  (utop)
  );

  // Doubled median from the two tops, and the same value halved toward zero.
  always_comb begin
    lsize_w  = TW'(lsize_q);
    usize_w  = TW'(usize_q);
    total    = lsize_w + usize_w;
    lt_ext   = MW'(ltop);
    ut_ext   = MW'(utop);
    samp_ext = MW'(sample_q);
    if (!total[0]) begin
      m2 = lt_ext + ut_ext;
    end else if (lsize_q > usize_q) begin
      m2 = lt_ext + lt_ext;
    end else begin
      m2 = ut_ext + ut_ext;
    end
    m2_adj = m2 + {{(MW-1){1'b0}}, m2[MW-1]};
    mt     = m2_adj >>> 1;
  end

  // Sequencer: next state, chain operations and output register loading.
  always_comb begin
    state_d     = state_q;
    lsize_d     = lsize_q;
    usize_d     = usize_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    lop         = OP_HOLD;
    uop         = OP_HOLD;
    lval        = sample_q;
    uval        = sample_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (total >= TW'(CAPACITY)) begin
          dropped_d = 1'b1;
          state_d   = ST_REPORT;
        end else begin
          dropped_d = 1'b0;
          if ((total == '0) || (samp_ext <= mt)) begin
            lop     = OP_INSERT;
            lsize_d = lsize_q + 1'b1;
          end else begin
            uop     = OP_INSERT;
            usize_d = usize_q + 1'b1;
          end
          state_d = ST_BALANCE;
        end
      end
      ST_BALANCE: begin
        if (lsize_w > usize_w + 1'b1) begin
          lop     = OP_POP;
          uop     = OP_INSERT;
          uval    = ltop;
          lsize_d = lsize_q - 1'b1;
          usize_d = usize_q + 1'b1;
        end else if (usize_w > lsize_w + 1'b1) begin
          uop     = OP_POP;
          lop     = OP_INSERT;
          lval    = utop;
          usize_d = usize_q - 1'b1;
          lsize_d = lsize_q + 1'b1;
        end
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lsize_q     <= '0;
      usize_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lsize_q     <= lsize_d;
      usize_q     <= usize_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers for the accepted sample and the pending result.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      sample_q <= sample_i;
    end
    if (out_load) begin
      median_q      <= m2;
      count_q       <= COUNT_BITS'(total);
      dropped_out_q <= dropped_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign median_x2_o = median_q;
  assign count_o     = count_q;
  assign dropped_o   = dropped_out_q;

endmodule

// ===== tb/sv/rmth_result_checker.sv =====
`timescale 1ns / 100ps

module rmth_result_checker import rmth_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [16:0] median_x2_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic               dropped_i,
  output int                 err_count_o,
  output int                 pending_o
);

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] median_t;

  typedef struct packed {
    logic signed [16:0]    median_x2;
    logic [COUNT_BITS-1:0] count;
    logic                  dropped;
  } median_result_t;

  // Both halves are kept sorted ascending: the lower half has its largest
  // value at the back and the upper half its smallest value at the front.
  sample_t        low_half[$];
  sample_t        high_half[$];
  median_result_t medians_due[$];
  int             errors;

  initial begin
    errors = 0;
  end

  // Places a sample into a sorted half.
  function automatic void insert_sorted(ref sample_t half[$], input sample_t value);
    int idx;
    idx = 0;
    while (idx < half.size() && half[idx] < value) idx++;
    half.insert(idx, value);
  endfunction

  // Twice the median of everything held; both tops are widened before the sum.
  function automatic median_t doubled_median();
    int      lo_n;
    int      hi_n;
    median_t a;
    median_t b;
    lo_n = low_half.size();
    hi_n = high_half.size();
    if (lo_n + hi_n == 0) return '0;
    if (lo_n == hi_n) begin
      a = low_half[$];
      b = high_half[0];
    end else if (lo_n > hi_n) begin
      a = low_half[$];
      b = a;
    end else begin
      a = high_half[0];
      b = a;
    end
    return a + b;
  endfunction

  // Adds one sample to the predicted set and returns the result it causes.
  function automatic median_result_t predict_median(input sample_t value);
    median_result_t res;
    median_t        m2;
    median_t        mt;
    sample_t        moved;
    int             held;
    held        = low_half.size() + high_half.size();
    res.dropped = 1'b0;
    if (held >= CAPACITY) begin
      res.dropped = 1'b1;
    end else if (held == 0) begin
      insert_sorted(low_half, value);
    end else begin
      // Signed division rounds toward zero, which is the routing rule.
      m2 = doubled_median();
      mt = m2 / 2;
      if (value <= mt) insert_sorted(low_half, value);
      else insert_sorted(high_half, value);
      if (low_half.size() > high_half.size() + 1) begin
        moved = low_half.pop_back();
        insert_sorted(high_half, moved);
      end else if (high_half.size() > low_half.size() + 1) begin
        moved = high_half.pop_front();
        insert_sorted(low_half, moved);
      end
    end
    res.median_x2 = doubled_median();
    res.count     = COUNT_BITS'(low_half.size() + high_half.size());
    return res;
  endfunction

  // Compares one field of a result transaction.
  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Results are checked before the same edge's input is predicted, since a
  // result can never belong to a sample accepted at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    median_result_t want;
    if (!rst_ni) begin
      medians_due.delete();
      low_half.delete();
      high_half.delete();
      pending_o   <= 0;
      err_count_o <= errors;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (medians_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected nothing, got %0d/%0d/%0d",
                   $time, median_x2_i, count_i, dropped_i);
        end else begin
          want = medians_due.pop_front();
          check_field("median_x2", int'(want.median_x2), int'(median_x2_i));
          check_field("count", int'(want.count), int'(count_i));
          check_field("dropped", int'(want.dropped), int'(dropped_i));
        end
      end
      if (in_valid_i && !in_stall_i) medians_due.push_back(predict_median(sample_i));
      pending_o   <= medians_due.size();
      err_count_o <= errors;
    end
  end

endmodule

// ===== tb/sv/tb_running_median_two_heaps_unit.sv =====
`timescale 1ns / 100ps

module tb_running_median_two_heaps_unit;
  import rmth_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int RANDOM_SAMPLES = 880;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_CYCLES     = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [15:0]    sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [16:0]    median_x2_o;
  logic [COUNT_BITS-1:0] count_o;
  logic                  dropped_o;

  int mismatches;
  int medians_pending;
  int hold_req;
  int burst_left;

  running_median_two_heaps_unit #(
    .CAPACITY   (CAPACITY),
    .SAMPLE_BITS(16)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .median_x2_o(median_x2_o),
    .count_o    (count_o),
    .dropped_o  (dropped_o)
  );

  rmth_result_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .median_x2_i(median_x2_o),
    .count_i    (count_o),
    .dropped_i  (dropped_o),
    .err_count_o(mismatches),
    .pending_o  (medians_pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one sample transaction, opening a new burst after a random gap
  // when the current burst is used up.
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // Stops offering samples until every predicted median has come back.
  task automatic wait_medians_returned();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (medians_pending != 0);
  endtask

  // Mix of full-range values, small values that produce ties and odd
  // doubled medians, values within 1000 of zero, and values at or near both extremes.
  function automatic logic signed [15:0] random_sample();
    int pick;
    int tmp;
    pick = $urandom_range(0, 9);
    case (pick)
      5, 6: begin
        tmp = int'($urandom_range(0, 16)) - 8;
        return 16'(tmp);
      end
      7: return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
      8: begin
        tmp = int'($urandom_range(0, 15));
        return ($urandom_range(0, 1) == 1) ? 16'(32767 - tmp) : 16'(-32768 + tmp);
      end
      9: begin
        tmp = int'($urandom_range(0, 2000)) - 1000;
        return 16'(tmp);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: changes its stall pattern at random intervals, and holds off
  // for a long stretch whenever the sender asks for it.
  initial begin
    int seen;
    int hold_left;
    int mode;
    int mode_left;
    seen        = 0;
    hold_left   = 0;
    mode        = 0;
    mode_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != seen) begin
        seen      = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          1: out_stall_i <= ($urandom_range(0, 1) == 1);
          2: out_stall_i <= ~out_stall_i;
          3: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int corner_samples[$];
    int i;
    corner_samples = {32767, 32767, -32768, -32768, -32768, 0, 0, -1, 1,
                      -3, -4, -3, -2, 3, 4, 3, 2, 5, 5, -7};
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    sample_i   <= '0;
    hold_req   <= 0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of the doubled median first, then ties and truncation toward
    // zero for odd doubled medians of either sign.
    foreach (corner_samples[k]) send_sample(16'(corner_samples[k]));

    // Random part, with a long receiver hold and a full drain partway through.
    for (i = 0; i < RANDOM_SAMPLES; i++) begin
      if (i == 300) hold_req <= hold_req + 1;
      if (i == 600) wait_medians_returned();
      send_sample(random_sample());
    end

    wait_medians_returned();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rmth_pkg.sv
rtl/core/rmth_cell.sv
rtl/core/rmth_chain.sv
rtl/core/running_median_two_heaps_unit.sv
tb/sv/rmth_result_checker.sv
tb/sv/tb_running_median_two_heaps_unit.sv
